FILE: hw/rtl/afpt_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed-point affine point transform unit.
// Holds the word types, matrix geometry, command codes and stream field offsets.
// Depends on nothing; used by every other file of the block.
package afpt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROWS      = 3;
  localparam int unsigned COLS      = 4;
  localparam int unsigned WORDS     = ROWS * COLS;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned PROD_W    = 2 * WORD_W;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IDX_LSB   = 0;
  localparam int unsigned VAL_LSB   = IDX_LSB + IDX_W;
  localparam int unsigned PX_LSB    = VAL_LSB + WORD_W;
  localparam int unsigned PY_LSB    = PX_LSB + WORD_W;
  localparam int unsigned PZ_LSB    = PY_LSB + WORD_W;
  localparam int unsigned IN_BITS   = PZ_LSB + WORD_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ROWS * WORD_W;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef word_t row_t [COLS];
  typedef word_t point_t [COLS-1];

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

endpackage

FILE: hw/rtl/afpt_lane.sv
`timescale 1ns / 1ps
// One row lane of the affine point transform: three multipliers and a row sum.
// Depends on afpt_pkg for word types and matrix geometry.
module afpt_lane #(
  parameter int unsigned FracBits = afpt_pkg::FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  afpt_pkg::row_t        row_i,
  input  afpt_pkg::point_t      point_i,
  output afpt_pkg::word_t       sum_o
);

  afpt_pkg::prod_t prod_q [afpt_pkg::COLS-1];
  afpt_pkg::word_t trans_q;

  // The w term is 1.0, so its floored product is the matrix word itself.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int j = 0; j < afpt_pkg::COLS - 1; j++) begin
        prod_q[j] <= afpt_pkg::prod_t'(row_i[j]) * afpt_pkg::prod_t'(point_i[j]);
      end
      trans_q <= row_i[afpt_pkg::COLS-1];
    end
  end

  always_comb begin
    sum_o = trans_q;
    for (int j = 0; j < afpt_pkg::COLS - 1; j++) begin
      sum_o = sum_o + afpt_pkg::word_t'(prod_q[j][FracBits +: afpt_pkg::WORD_W]);
    end
  end

endmodule

FILE: hw/rtl/fixed_point_affine_point_transform_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed-point affine point transform unit.
// Instantiates three afpt_lane row lanes and merges them into one output register.
// Depends on afpt_pkg and afpt_lane.
//
//  Channel    | Direction | tdata (low bit first)                          | tuser
//  s_axis     | in        | element_index, element_value, point_x/y/z      | command
//  m_axis     | out       | out_x, out_y, out_z                            | -
//
// A transform transaction is registered first in the lane multiplier products, then in
// the output register that the row adders feed.
// One transaction is accepted every cycle unless m_axis stalls; the rate comes from
// three parallel row lanes of three registered 32x32 multipliers and a row adder.
// A matrix write is applied at its accept edge and is seen by the next transform.
// Reset clears the matrix store to zero and empties the pipeline.
// When the output is stalled, the lane stage holds one item and then s_axis stalls.
module fixed_point_affine_point_transform_unit #(
  parameter int unsigned FracBits = afpt_pkg::FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // element_index[3:0], element_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], zero fill[135:132]
  input  logic [afpt_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // command: 0 writes a matrix word, 1 transforms a point
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [afpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  // Matrix store, twelve words row-major, cleared by reset.
  afpt_pkg::word_t matrix_q [afpt_pkg::WORDS];
  afpt_pkg::word_t matrix_d [afpt_pkg::WORDS];

  logic                         lane_valid_q;
  logic                         lane_valid_d;
  logic                         out_valid_q;
  logic                         out_valid_d;
  afpt_pkg::word_t              out_q [afpt_pkg::ROWS];
  afpt_pkg::word_t              lane_sum [afpt_pkg::ROWS];
  afpt_pkg::row_t               rows [afpt_pkg::ROWS];
  afpt_pkg::point_t             point;

  logic                         out_free;
  logic                         in_fire;
  logic                         xform_fire;
  logic [afpt_pkg::IDX_W-1:0]   wr_idx;
  afpt_pkg::word_t              wr_val;

  // Handshake: the output register frees when empty or being taken, and the
  // lane stage can take a new item whenever it can pass its own along.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !lane_valid_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign xform_fire      = in_fire && (s_axis_tuser_i == afpt_pkg::CMD_XFORM);

  assign wr_idx = s_axis_tdata_i[afpt_pkg::IDX_LSB +: afpt_pkg::IDX_W];
  assign wr_val = s_axis_tdata_i[afpt_pkg::VAL_LSB +: afpt_pkg::WORD_W];
  assign point[0] = s_axis_tdata_i[afpt_pkg::PX_LSB +: afpt_pkg::WORD_W];
  assign point[1] = s_axis_tdata_i[afpt_pkg::PY_LSB +: afpt_pkg::WORD_W];
  assign point[2] = s_axis_tdata_i[afpt_pkg::PZ_LSB +: afpt_pkg::WORD_W];

  // Word writes; indexes past the twelfth word match no entry and are dropped.
  always_comb begin
    for (int k = 0; k < afpt_pkg::WORDS; k++) begin
      matrix_d[k] = matrix_q[k];
      if (in_fire && (s_axis_tuser_i == afpt_pkg::CMD_WRITE) &&
          (wr_idx == afpt_pkg::IDX_W'(k))) begin
        matrix_d[k] = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < afpt_pkg::WORDS; k++) begin
        matrix_q[k] <= '0;
      end
    end else begin
      matrix_q <= matrix_d;
    end
  end

  // Each lane sees its own row of the store.
  always_comb begin
    for (int r = 0; r < afpt_pkg::ROWS; r++) begin
      for (int c = 0; c < afpt_pkg::COLS; c++) begin
        rows[r][c] = matrix_q[r * afpt_pkg::COLS + c];
      end
    end
  end

  for (genvar r = 0; r < afpt_pkg::ROWS; r++) begin : g_lane
    afpt_lane #(
      .FracBits (FracBits)
    ) u_lane (
      .clk_i   (clk_i),
      .load_i  (xform_fire),
      .row_i   (rows[r]),
      .point_i (point),
      .sum_o   (lane_sum[r])
    );
  end

  // Valid tracking for the lane stage and the merged output register.
  always_comb begin
    lane_valid_d = lane_valid_q;
    if (s_axis_tready_o) begin
      lane_valid_d = xform_fire;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = lane_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      lane_valid_q <= lane_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Merge stage: the three row sums land together in the output register.
  always_ff @(posedge clk_i) begin
    if (out_free && lane_valid_q) begin
      out_q <= lane_sum;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q[2], out_q[1], out_q[0]};

endmodule

FILE: hw/rtl/afpt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the fixed-point affine point transform unit.
// Depends on afpt_pkg; bound to fixed_point_affine_point_transform_unit below.
module afpt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [afpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  logic xform_accept;
  assign xform_accept = s_axis_tvalid_i && s_axis_tready_o &&
                        (s_axis_tuser_i == afpt_pkg::CMD_XFORM);

  // The output side is empty while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A result held back by the sink keeps its data.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // A fresh result comes from an accepted transform that passed the lane stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(xform_accept, 2))
    else $error("result without a matching transform");

  // Whenever the output can move, the input side is open.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while output free");

endmodule

bind fixed_point_affine_point_transform_unit afpt_checker u_afpt_checker (.*);
